// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define TCC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define TCC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tcc_pkg.sv =====
// ----------------------------------------------------------------------------
// tcc_pkg
// Constants and helpers shared by the circumcenter pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tcc_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  // Width of one multiplier slice; one slice is consumed per stage
  localparam int MUL_CHUNK = 16;
  // Output field width
  localparam int OUT_W = 48;
  // Root width: square root of a sum of two OUT_W-bit squares
  localparam int RAD_RB = OUT_W + 1;

  // Latency of tcc_mul for a BW-bit second operand
  function automatic int mul_lat(input int bw);
    return (bw + MUL_CHUNK - 1) / MUL_CHUNK + 2;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tcc_in_if.sv =====
// ----------------------------------------------------------------------------
// tcc_in_if
// Triangle item channel: three corners, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcc_in_if #(
  parameter int COORD_WIDTH = tcc_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] ax;
  logic signed [COORD_WIDTH-1:0] ay;
  logic signed [COORD_WIDTH-1:0] bx;
  logic signed [COORD_WIDTH-1:0] by;
  logic signed [COORD_WIDTH-1:0] cx;
  logic signed [COORD_WIDTH-1:0] cy;

  modport source (output valid, ax, ay, bx, by, cx, cy, input ready);
  modport sink   (input valid, ax, ay, bx, by, cx, cy, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tcc_out_if.sv =====
// ----------------------------------------------------------------------------
// tcc_out_if
// Result item channel: centre, radius and flat flag, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcc_out_if;
  import tcc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] centre_x;
  logic signed [OUT_W-1:0] centre_y;
  logic        [OUT_W-1:0] radius;
  logic                    flat;

  modport source (output valid, centre_x, centre_y, radius, flat, input ready);
  modport sink   (input valid, centre_x, centre_y, radius, flat, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tcc_dly.sv =====
// ----------------------------------------------------------------------------
// tcc_dly
// Enabled shift line that carries side data and valid bits past a unit.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_dly #(
  parameter int WD    = 8,
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic [WD-1:0] d,
  output logic [WD-1:0] q
);

  logic [WD-1:0] sh_r [DEPTH];

  // Advance the line on enable, clear on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) sh_r[i] <= '0;
    end else if (en) begin
      sh_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) sh_r[i] <= sh_r[i-1];
    end
  end

  assign q = sh_r[DEPTH-1];

endmodule

`default_nettype wire

// ===== hw/rtl/tcc_mul.sv =====
// ----------------------------------------------------------------------------
// tcc_mul
// Pipelined signed multiplier: sign/magnitude split, one MUL_CHUNK-bit slice
// of the second operand per stage, sign restored in the last stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_mul #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);
  import tcc_pkg::*;

  localparam int NCH = (BW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int BP  = NCH * MUL_CHUNK;
  localparam int PW  = AW + BW;

  logic [AW-1:0] amag;
  logic [BW-1:0] bmag;
  logic [AW-1:0] am_r  [NCH];
  logic [BP-1:0] bm_r  [NCH];
  logic          neg_r [NCH+1];
  logic [PW-1:0] acc_r [NCH+1];
  logic [PW-1:0] p_r;

  assign amag = a[AW-1] ? AW'(-a) : AW'(a);
  assign bmag = b[BW-1] ? BW'(-b) : BW'(b);

  // Split into sign and magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      am_r[0]  <= amag;
      bm_r[0]  <= BP'(bmag);
      neg_r[0] <= a[AW-1] ^ b[BW-1];
      acc_r[0] <= '0;
    end
  end

  // Accumulate one partial product per stage
  for (genvar k = 1; k <= NCH; k++) begin : g_slice
    logic [AW+MUL_CHUNK-1:0] pp;
    assign pp = am_r[k-1] * bm_r[k-1][MUL_CHUNK*(k-1) +: MUL_CHUNK];

    always_ff @(posedge clk) begin
      if (en) begin
        acc_r[k] <= acc_r[k-1] + (PW'(pp) << (MUL_CHUNK * (k - 1)));
        neg_r[k] <= neg_r[k-1];
      end
    end

    if (k < NCH) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          am_r[k] <= am_r[k-1];
          bm_r[k] <= bm_r[k-1];
        end
      end
    end
  end

  // Restore the sign
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= neg_r[NCH] ? -acc_r[NCH] : acc_r[NCH];
    end
  end

  assign p = signed'(p_r);

endmodule

`default_nettype wire

// ===== hw/rtl/tcc_div.sv =====
// ----------------------------------------------------------------------------
// tcc_div
// Pipelined signed divider, restoring, one quotient bit per stage,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_div #(
  parameter int NW = 103,
  parameter int DW = 68
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [NW-1:0] n,
  input  logic signed [DW-1:0] d,
  output logic signed [NW:0]   q
);

  localparam int RW = DW + 1;

  logic [NW-1:0] nmag;
  logic [DW-1:0] dmag;
  logic [NW-1:0] nq_r  [NW+1];
  logic [RW-1:0] r_r   [NW];
  logic [DW-1:0] dm_r  [NW];
  logic          neg_r [NW+1];
  logic [NW:0]   q_r;

  assign nmag = n[NW-1] ? NW'(-n) : NW'(n);
  assign dmag = d[DW-1] ? DW'(-d) : DW'(d);

  // Split into sign and magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      nq_r[0]  <= nmag;
      r_r[0]   <= '0;
      dm_r[0]  <= dmag;
      neg_r[0] <= n[NW-1] ^ d[DW-1];
    end
  end

  // Shift in one dividend bit, subtract when the remainder allows
  for (genvar k = 1; k <= NW; k++) begin : g_bit
    logic [RW-1:0] rn;
    logic          ge;
    assign rn = {r_r[k-1][RW-2:0], nq_r[k-1][NW-1]};
    assign ge = (rn >= RW'(dm_r[k-1]));

    always_ff @(posedge clk) begin
      if (en) begin
        nq_r[k]  <= {nq_r[k-1][NW-2:0], ge};
        neg_r[k] <= neg_r[k-1];
      end
    end

    if (k < NW) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          r_r[k]  <= ge ? (rn - RW'(dm_r[k-1])) : rn;
          dm_r[k] <= dm_r[k-1];
        end
      end
    end
  end

  // Restore the sign
  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= neg_r[NW] ? -(NW+1)'(nq_r[NW]) : (NW+1)'(nq_r[NW]);
    end
  end

  assign q = signed'(q_r);

endmodule

`default_nettype wire

// ===== hw/rtl/tcc_sqrt.sv =====
// ----------------------------------------------------------------------------
// tcc_sqrt
// Pipelined integer square root, restoring, one root bit per stage,
// result truncated.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_sqrt #(
  parameter int RB = 49
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*RB-1:0] s,
  output logic [RB-1:0]   root
);

  localparam int TW = RB + 2;

  logic [2*RB-1:0] s_r    [RB];
  logic [TW-1:0]   rem_r  [RB];
  logic [RB-1:0]   root_r [RB+1];

  // Capture the radicand
  always_ff @(posedge clk) begin
    if (en) begin
      s_r[0]    <= s;
      rem_r[0]  <= '0;
      root_r[0] <= '0;
    end
  end

  // Bring down two radicand bits, try the next root bit
  for (genvar k = 1; k <= RB; k++) begin : g_bit
    logic [TW-1:0] rn;
    logic [TW-1:0] trial;
    logic          ge;
    assign rn    = {rem_r[k-1][RB-1:0], s_r[k-1][2*RB-1 -: 2]};
    assign trial = {root_r[k-1], 2'b01};
    assign ge    = (rn >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k] <= {root_r[k-1][RB-2:0], ge};
      end
    end

    if (k < RB) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? (rn - trial) : rn;
          s_r[k]   <= s_r[k-1] << 2;
        end
      end
    end
  end

  assign root = root_r[RB];

endmodule

`default_nettype wire

// ===== hw/rtl/triangle_circumcentre.sv =====
// ----------------------------------------------------------------------------
// triangle_circumcentre
// Circumcenter and circumradius of a triangle in signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one triangle per item (corners A, B, C); out_ch returns
//   one result per item, in order: centre, radius to corner A, flat flag.
//   Collinear corners give flat = 1 with centre and radius zero.
// Throughput: one item per cycle, no gaps between items, while out_ch is not stalled.
// Pipeline depth: set mainly by the divider, one quotient bit per stage over
//   the 3*COORD_WIDTH+7 bit numerator, and by the 49-stage square root.
// Reset: rst_n low for one clock empties the pipeline; nothing is in
//   flight afterward.
// Stall: while out_ch.ready is low and a result waits, the whole pipeline
//   holds and in_ch.ready drops; no item is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_circumcentre #(
  parameter int COORD_WIDTH = tcc_pkg::COORD_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  tcc_in_if.sink      in_ch,
  tcc_out_if.source   out_ch
);
  import tcc_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int DFW = W + 1;          // corner differences
  localparam int PRW = 2 * DFW;        // difference products
  localparam int BBW = PRW + 1;        // squared side lengths
  localparam int DW  = BBW + 1;        // determinant
  localparam int MW  = DW + DFW;       // second-level products
  localparam int NW  = MW + 2;         // numerators
  localparam int QW  = NW + 1;         // quotients
  localparam int OW  = QW + 1;         // offset from corner A
  localparam int SW  = 2 * RAD_RB;     // radicand
  localparam int L1  = mul_lat(DFW);
  localparam int LD  = NW + 2;
  localparam int LS  = mul_lat(RAD_RB);
  localparam int LR  = RAD_RB + 1;

  localparam logic signed [OUT_W-1:0] CMAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] CMIN = {1'b1, {(OUT_W-1){1'b0}}};
  localparam logic [OUT_W-1:0]        RMAX = '1;

  logic en;
  logic out_valid_r;

  // Whole pipeline advances unless a result waits at the output
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // Clamp a quotient to the output range
  function automatic logic signed [OUT_W-1:0] sat_centre(input logic signed [QW-1:0] t);
    logic hi_one;
    logic hi_zero;
    hi_one  = &t[QW-1:OUT_W-1];
    hi_zero = ~|t[QW-1:OUT_W-1];
    if (hi_one || hi_zero) return t[OUT_W-1:0];
    else if (t[QW-1])      return CMIN;
    else                   return CMAX;
  endfunction

  // ---------------- stage 0: input register
  logic                v0_r;
  logic signed [W-1:0] ax0_r, ay0_r, bx0_r, by0_r, cx0_r, cy0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (en) v0_r <= in_ch.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax0_r <= in_ch.ax;
      ay0_r <= in_ch.ay;
      bx0_r <= in_ch.bx;
      by0_r <= in_ch.by;
      cx0_r <= in_ch.cx;
      cy0_r <= in_ch.cy;
    end
  end

  // ---------------- stage 1: sides relative to corner A
  logic                  v1_r;
  logic signed [W-1:0]   ax1_r, ay1_r;
  logic signed [DFW-1:0] ubx1_r, uby1_r, ucx1_r, ucy1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= v0_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax1_r  <= ax0_r;
      ay1_r  <= ay0_r;
      ubx1_r <= DFW'(bx0_r) - DFW'(ax0_r);
      uby1_r <= DFW'(by0_r) - DFW'(ay0_r);
      ucx1_r <= DFW'(cx0_r) - DFW'(ax0_r);
      ucy1_r <= DFW'(cy0_r) - DFW'(ay0_r);
    end
  end

  // ---------------- first multiplier bank: squares and cross products
  logic signed [PRW-1:0] p_bxx, p_byy, p_cxx, p_cyy, p_bxcy, p_bycx;

  tcc_mul #(.AW(DFW), .BW(DFW)) u_mul_bxx (.clk, .en, .a(ubx1_r), .b(ubx1_r), .p(p_bxx));
  tcc_mul #(.AW(DFW), .BW(DFW)) u_mul_byy (.clk, .en, .a(uby1_r), .b(uby1_r), .p(p_byy));
  tcc_mul #(.AW(DFW), .BW(DFW)) u_mul_cxx (.clk, .en, .a(ucx1_r), .b(ucx1_r), .p(p_cxx));
  tcc_mul #(.AW(DFW), .BW(DFW)) u_mul_cyy (.clk, .en, .a(ucy1_r), .b(ucy1_r), .p(p_cyy));
  tcc_mul #(.AW(DFW), .BW(DFW)) u_mul_bxcy (.clk, .en, .a(ubx1_r), .b(ucy1_r), .p(p_bxcy));
  tcc_mul #(.AW(DFW), .BW(DFW)) u_mul_bycx (.clk, .en, .a(uby1_r), .b(ucx1_r), .p(p_bycx));

  localparam int D1W = 1 + 2 * W + 4 * DFW;
  logic [D1W-1:0]        d1_out;
  logic                  v1d;
  logic signed [W-1:0]   ax1d, ay1d;
  logic signed [DFW-1:0] ubx1d, uby1d, ucx1d, ucy1d;

  tcc_dly #(.WD(D1W), .DEPTH(L1)) u_dly1 (
    .clk, .rst_n, .en,
    .d({v1_r, ax1_r, ay1_r, ubx1_r, uby1_r, ucx1_r, ucy1_r}),
    .q(d1_out)
  );
  assign {v1d, ax1d, ay1d, ubx1d, uby1d, ucx1d, ucy1d} = d1_out;

  // ---------------- stage 2: side lengths squared and determinant
  logic                  v2_r;
  logic signed [W-1:0]   ax2_r, ay2_r;
  logic signed [DFW-1:0] ubx2_r, uby2_r, ucx2_r, ucy2_r;
  logic signed [BBW-1:0] bb2_r, cc2_r;
  logic signed [DW-1:0]  d2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1d;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax2_r  <= ax1d;
      ay2_r  <= ay1d;
      ubx2_r <= ubx1d;
      uby2_r <= uby1d;
      ucx2_r <= ucx1d;
      ucy2_r <= ucy1d;
      bb2_r  <= BBW'(p_bxx) + BBW'(p_byy);
      cc2_r  <= BBW'(p_cxx) + BBW'(p_cyy);
      d2_r   <= (DW'(p_bxcy) - DW'(p_bycx)) << 1;
    end
  end

  // ---------------- second multiplier bank: numerator terms
  logic signed [MW-1:0] m_cybb, m_bycc, m_bxcc, m_cxbb, m_axd, m_ayd;

  tcc_mul #(.AW(DW), .BW(DFW)) u_mul_cybb (
    .clk, .en, .a(DW'(bb2_r)), .b(ucy2_r), .p(m_cybb));
  tcc_mul #(.AW(DW), .BW(DFW)) u_mul_bycc (
    .clk, .en, .a(DW'(cc2_r)), .b(uby2_r), .p(m_bycc));
  tcc_mul #(.AW(DW), .BW(DFW)) u_mul_bxcc (
    .clk, .en, .a(DW'(cc2_r)), .b(ubx2_r), .p(m_bxcc));
  tcc_mul #(.AW(DW), .BW(DFW)) u_mul_cxbb (
    .clk, .en, .a(DW'(bb2_r)), .b(ucx2_r), .p(m_cxbb));
  tcc_mul #(.AW(DW), .BW(DFW)) u_mul_axd (
    .clk, .en, .a(d2_r), .b(DFW'(ax2_r)), .p(m_axd));
  tcc_mul #(.AW(DW), .BW(DFW)) u_mul_ayd (
    .clk, .en, .a(d2_r), .b(DFW'(ay2_r)), .p(m_ayd));

  localparam int D2W = 1 + 2 * W + DW;
  logic [D2W-1:0]       d2_out;
  logic                 v2d;
  logic signed [W-1:0]  ax2d, ay2d;
  logic signed [DW-1:0] dd2d;

  tcc_dly #(.WD(D2W), .DEPTH(L1)) u_dly2 (
    .clk, .rst_n, .en,
    .d({v2_r, ax2_r, ay2_r, d2_r}),
    .q(d2_out)
  );
  assign {v2d, ax2d, ay2d, dd2d} = d2_out;

  // ---------------- stage 3: full numerators, flat detect
  logic                 v3_r, flat3_r;
  logic signed [W-1:0]  ax3_r, ay3_r;
  logic signed [NW-1:0] nx3_r, ny3_r;
  logic signed [DW-1:0] d3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2d;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax3_r   <= ax2d;
      ay3_r   <= ay2d;
      d3_r    <= dd2d;
      flat3_r <= (dd2d == '0);
      nx3_r   <= NW'(m_axd) + NW'(m_cybb) - NW'(m_bycc);
      ny3_r   <= NW'(m_ayd) + NW'(m_bxcc) - NW'(m_cxbb);
    end
  end

  // ---------------- dividers
  logic signed [QW-1:0] tx, ty;

  tcc_div #(.NW(NW), .DW(DW)) u_div_x (.clk, .en, .n(nx3_r), .d(d3_r), .q(tx));
  tcc_div #(.NW(NW), .DW(DW)) u_div_y (.clk, .en, .n(ny3_r), .d(d3_r), .q(ty));

  localparam int D3W = 2 + 2 * W;
  logic [D3W-1:0]      d3_out;
  logic                v3d, flat3d;
  logic signed [W-1:0] ax3d, ay3d;

  tcc_dly #(.WD(D3W), .DEPTH(LD)) u_dly3 (
    .clk, .rst_n, .en,
    .d({v3_r, flat3_r, ax3_r, ay3_r}),
    .q(d3_out)
  );
  assign {v3d, flat3d, ax3d, ay3d} = d3_out;

  // ---------------- stage 4: offset from corner A
  logic                 v4_r, flat4_r;
  logic signed [QW-1:0] tx4_r, ty4_r;
  logic signed [OW-1:0] ox4_r, oy4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= v3d;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flat4_r <= flat3d;
      tx4_r   <= tx;
      ty4_r   <= ty;
      ox4_r   <= OW'(tx) - OW'(ax3d);
      oy4_r   <= OW'(ty) - OW'(ay3d);
    end
  end

  // ---------------- stage 5: clamp centre, magnitudes of the offset
  logic [OW-1:0] oxa, oya;
  assign oxa = ox4_r[OW-1] ? OW'(-ox4_r) : OW'(ox4_r);
  assign oya = oy4_r[OW-1] ? OW'(-oy4_r) : OW'(oy4_r);

  logic                    v5_r, flat5_r, big5_r;
  logic signed [OUT_W-1:0] cx5_r, cy5_r;
  logic [OUT_W-1:0]        mx5_r, my5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (en) v5_r <= v4_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flat5_r <= flat4_r;
      cx5_r   <= flat4_r ? '0 : sat_centre(tx4_r);
      cy5_r   <= flat4_r ? '0 : sat_centre(ty4_r);
      big5_r  <= (|oxa[OW-1:OUT_W]) || (|oya[OW-1:OUT_W]);
      mx5_r   <= oxa[OUT_W-1:0];
      my5_r   <= oya[OUT_W-1:0];
    end
  end

  // ---------------- squares of the offset
  logic signed [SW-1:0] sqx, sqy;

  tcc_mul #(.AW(RAD_RB), .BW(RAD_RB)) u_mul_sqx (
    .clk, .en, .a(signed'({1'b0, mx5_r})), .b(signed'({1'b0, mx5_r})), .p(sqx));
  tcc_mul #(.AW(RAD_RB), .BW(RAD_RB)) u_mul_sqy (
    .clk, .en, .a(signed'({1'b0, my5_r})), .b(signed'({1'b0, my5_r})), .p(sqy));

  localparam int D4W = 3 + 2 * OUT_W;
  logic [D4W-1:0]          d4_out;
  logic                    v5d, flat5d, big5d;
  logic signed [OUT_W-1:0] cx5d, cy5d;

  tcc_dly #(.WD(D4W), .DEPTH(LS)) u_dly4 (
    .clk, .rst_n, .en,
    .d({v5_r, flat5_r, big5_r, cx5_r, cy5_r}),
    .q(d4_out)
  );
  assign {v5d, flat5d, big5d, cx5d, cy5d} = d4_out;

  // ---------------- stage 6: radicand
  logic                    v6_r, flat6_r, big6_r;
  logic signed [OUT_W-1:0] cx6_r, cy6_r;
  logic [SW-1:0]           s6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else if (en) v6_r <= v5d;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flat6_r <= flat5d;
      big6_r  <= big5d;
      cx6_r   <= cx5d;
      cy6_r   <= cy5d;
      s6_r    <= SW'(unsigned'(sqx)) + SW'(unsigned'(sqy));
    end
  end

  // ---------------- square root
  logic [RAD_RB-1:0] root;

  tcc_sqrt #(.RB(RAD_RB)) u_sqrt (.clk, .en, .s(s6_r), .root(root));

  logic [D4W-1:0]          d5_out;
  logic                    v6d, flat6d, big6d;
  logic signed [OUT_W-1:0] cx6d, cy6d;

  tcc_dly #(.WD(D4W), .DEPTH(LR)) u_dly5 (
    .clk, .rst_n, .en,
    .d({v6_r, flat6_r, big6_r, cx6_r, cy6_r}),
    .q(d5_out)
  );
  assign {v6d, flat6d, big6d, cx6d, cy6d} = d5_out;

  // ---------------- output register
  logic [OUT_W-1:0]        radius_nxt;
  logic signed [OUT_W-1:0] centre_x_r, centre_y_r;
  logic [OUT_W-1:0]        radius_r;
  logic                    flat_r;

  // Cap the radius, zero it for a flat triangle
  always_comb begin
    if (flat6d)                       radius_nxt = '0;
    else if (big6d || root[OUT_W])    radius_nxt = RMAX;
    else                              radius_nxt = root[OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= v6d;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      centre_x_r <= cx6d;
      centre_y_r <= cy6d;
      radius_r   <= radius_nxt;
      flat_r     <= flat6d;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.centre_x = centre_x_r;
  assign out_ch.centre_y = centre_y_r;
  assign out_ch.radius   = radius_r;
  assign out_ch.flat     = flat_r;

endmodule

`default_nettype wire

// ===== hw/rtl/tcc_chk.sv =====
// ----------------------------------------------------------------------------
// tcc_chk
// Port-level checks on the circumcenter block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tcc_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [tcc_pkg::OUT_W-1:0] centre_x,
  input logic signed [tcc_pkg::OUT_W-1:0] centre_y,
  input logic        [tcc_pkg::OUT_W-1:0] radius,
  input logic                             flat
);

  // Hold a stalled result
  `TCC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `TCC_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(centre_x) && $stable(centre_y) && $stable(radius) && $stable(flat), "stalled result changed")

  // Flat triangle carries zero centre and radius
  `TCC_ASSERT_IMP(a_flat_zero, out_valid && flat, centre_x == '0 && centre_y == '0 && radius == '0, "flat result not zero")

  // Input is refused only while a result waits
  `TCC_ASSERT_IMP(a_ready_stall, !in_ready, out_valid && !out_ready, "input refused without stall")

endmodule

bind triangle_circumcentre tcc_chk u_tcc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .centre_x  (out_ch.centre_x),
  .centre_y  (out_ch.centre_y),
  .radius    (out_ch.radius),
  .flat      (out_ch.flat)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Circumcenter pipeline check: directed and random triangles are streamed
// through the block under random sender and receiver idling. Each result is
// compared field by field with an exact wide-integer prediction of the
// centre, radius and flat flag.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import tcc_pkg::*;

  localparam int CW = 32;
  localparam int DRAIN_CYCLES = 250;
  localparam int N_RANDOM = 600;

  typedef logic signed [255:0] wide_t;

  typedef struct packed {
    logic signed [CW-1:0] ax, ay, bx, by, cx, cy;
  } corners_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] centre_x;
    logic signed [OUT_W-1:0] centre_y;
    logic [OUT_W-1:0]        radius;
    logic                    flat;
  } circle_t;

  logic clk;
  logic rst_n;
  int   src_idle_pct;
  int   snk_idle_pct;
  int   mismatches;
  circle_t circles_pending[$];

  tcc_in_if #(.COORD_WIDTH(CW)) in_ch();
  tcc_out_if out_ch();

  triangle_circumcentre #(.COORD_WIDTH(CW)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Clamp a truncated centre coordinate to the signed output range
  function automatic logic signed [OUT_W-1:0] clamp_coord(input wide_t t);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (OUT_W - 1)) - 1;
    lo = -(wide_t'(1) <<< (OUT_W - 1));
    if (t > hi) t = hi;
    if (t < lo) t = lo;
    return t[OUT_W-1:0];
  endfunction

  // Truncated distance from corner A to the unclamped centre
  function automatic logic [OUT_W-1:0] radius_to_a(input wide_t ox, input wide_t oy);
    logic [255:0] mx;
    logic [255:0] my;
    logic [255:0] sum;
    logic [255:0] root;
    logic [255:0] cand;
    logic [255:0] lim;
    mx = (ox < 0) ? -ox : ox;
    my = (oy < 0) ? -oy : oy;
    lim = 256'd1 << OUT_W;
    if (mx >= lim || my >= lim) return {OUT_W{1'b1}};
    sum = mx * mx + my * my;
    root = '0;
    for (int b = OUT_W + 1; b >= 0; b--) begin
      cand = root | (256'd1 << b);
      if (cand * cand <= sum) root = cand;
    end
    if (root >= lim) return {OUT_W{1'b1}};
    return root[OUT_W-1:0];
  endfunction

  // Exact circumcenter of one triangle
  function automatic circle_t circumcentre_of(input corners_t t);
    wide_t ax, ay, ubx, uby, ucx, ucy, bb, cc, det, nx, ny, tx, ty;
    circle_t r;
    ax  = t.ax;
    ay  = t.ay;
    ubx = wide_t'(t.bx) - ax;
    uby = wide_t'(t.by) - ay;
    ucx = wide_t'(t.cx) - ax;
    ucy = wide_t'(t.cy) - ay;
    bb  = ubx * ubx + uby * uby;
    cc  = ucx * ucx + ucy * ucy;
    det = 2 * (ubx * ucy - uby * ucx);
    r = '0;
    if (det == 0) begin
      r.flat = 1'b1;
      return r;
    end
    nx = ucy * bb - uby * cc;
    ny = ubx * cc - ucx * bb;
    tx = (ax * det + nx) / det;
    ty = (ay * det + ny) / det;
    r.centre_x = clamp_coord(tx);
    r.centre_y = clamp_coord(ty);
    r.radius   = radius_to_a(tx - ax, ty - ay);
    return r;
  endfunction

  // Send one triangle, idling at random first; valid stays high afterward
  task automatic send_triangle(input corners_t t);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.ax <= t.ax;
    in_ch.ay <= t.ay;
    in_ch.bx <= t.bx;
    in_ch.by <= t.by;
    in_ch.cx <= t.cx;
    in_ch.cy <= t.cy;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    circles_pending.push_back(circumcentre_of(t));
  endtask

  // Drop valid and hold off until every result is back
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (circles_pending.size() != 0) @(posedge clk);
  endtask

  function automatic corners_t corners(input int ax, ay, bx, by, cx, cy);
    corners_t t;
    t.ax = ax; t.ay = ay; t.bx = bx; t.by = by; t.cx = cx; t.cy = cy;
    return t;
  endfunction

  // Random triangle: full range, small, near-collinear, or degenerate
  function automatic corners_t random_triangle();
    corners_t t;
    int kind;
    int k;
    kind = $urandom_range(9);
    t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if (kind >= 4 && kind <= 6) begin
      t.ax = $signed($urandom_range(131071)) - 65536;
      t.ay = $signed($urandom_range(131071)) - 65536;
      t.bx = $signed($urandom_range(131071)) - 65536;
      t.by = $signed($urandom_range(131071)) - 65536;
      t.cx = $signed($urandom_range(131071)) - 65536;
      t.cy = $signed($urandom_range(131071)) - 65536;
    end else if (kind >= 7) begin
      // C lies near the line through A and B
      t.ax = $signed($urandom_range(1 << 20)) - (1 << 19);
      t.ay = $signed($urandom_range(1 << 20)) - (1 << 19);
      t.bx = t.ax + $signed($urandom_range(1 << 16)) - (1 << 15);
      t.by = t.ay + $signed($urandom_range(1 << 16)) - (1 << 15);
      k = $signed($urandom_range(8)) - 4;
      t.cx = t.ax + k * (t.bx - t.ax) + ((kind == 9) ? 0 : $signed($urandom_range(2)) - 1);
      t.cy = t.ay + k * (t.by - t.ay) + ((kind == 9) ? 0 : $signed($urandom_range(2)) - 1);
    end
    return t;
  endfunction

  // Extremes, degenerate shapes and saturating centres
  task automatic test_directed();
    localparam int MX = 32'h7fffffff;
    localparam int MN = 32'h80000000;
    send_triangle(corners(0, 0, 0, 0, 0, 0));
    send_triangle(corners(MX, MX, MX, MX, MX, MX));
    send_triangle(corners(MN, MN, MX, MX, 0, 0));
    send_triangle(corners(0, 0, 65536, 0, 0, 65536));
    send_triangle(corners(MX, MN, MN, MX, MN, MN));
    send_triangle(corners(MN, MN, MX, MN, MX, MX));
    send_triangle(corners(MX, MX, MN, MX, MN, MN));
    send_triangle(corners(MN, 0, MX, 0, 0, 1));
    send_triangle(corners(MN, MN, MX, MX, MX, MX - 1));
    send_triangle(corners(0, 0, 1, 0, 0, 1));
    send_triangle(corners(-65536, -65536, 65536, 0, 0, 65536));
    send_triangle(corners(-1, -1, -1, -1, 0, 0));
    send_triangle(corners(0, 0, 2, 2, 4, 4));
    send_triangle(corners(MX, 0, MN, 0, MN + 1, 1));
    send_triangle(corners(0, MX, 0, MN, 1, 0));
    send_triangle(corners(-32'sh5555_5555, 32'sh2aaa_aaaa, MX, MN, 12345, -999));
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) send_triangle(random_triangle());
  endtask

  // Compare each result with the oldest prediction; drive ready at random
  always @(posedge clk) begin
    circle_t want;
    circle_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.centre_x, out_ch.centre_y, out_ch.radius, out_ch.flat};
      if (circles_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = circles_pending.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10) $display("expected %p got %p", want, got);
        end
      end
    end
    out_ch.ready <= rst_n && ($urandom_range(99) >= snk_idle_pct);
  end

  // Stimulus sequence
  initial begin
    mismatches = 0;
    src_idle_pct = 28;
    snk_idle_pct = 85;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.ax = '0; in_ch.ay = '0; in_ch.bx = '0;
    in_ch.by = '0; in_ch.cx = '0; in_ch.cy = '0;
    out_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    wait_for_results();
    test_random(N_RANDOM);
    src_idle_pct = 85;
    snk_idle_pct = 28;
    test_random(N_RANDOM);
    wait_for_results();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random(N_RANDOM);
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && circles_pending.size() == 0) begin
      $display("triangle_circumcentre: match");
    end else begin
      $display("triangle_circumcentre: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("triangle_circumcentre: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
